// ===== rtl/pwpm_pkg.sv =====
// pwpm_pkg: shared constants, codes and types for the pulse width / period meter
// used by pwpm_front, pwpm_queue, pwpm_back and pulse_width_period_meter
package pwpm_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNITS_MS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_US_SCALE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 3'd4;

    localparam logic [23:0] US_SCALE_RST    = 24'd1137778;
    localparam logic [19:0] SAMPLE_RATE_RST = 20'd57600;

    localparam logic [3:0] MODE_HIGH_FALL  = 4'd0;
    localparam logic [3:0] MODE_LOW_RISE   = 4'd1;
    localparam logic [3:0] MODE_COUNT_FALL = 4'd2;
    localparam logic [3:0] MODE_PER_RISE   = 4'd3;
    localparam logic [3:0] MODE_PER_FALL   = 4'd4;
    localparam logic [3:0] MODE_FREQ_RISE  = 4'd5;
    localparam logic [3:0] MODE_FREQ_FALL  = 4'd6;
    localparam logic [3:0] MODE_DUTY_RISE  = 4'd7;
    localparam logic [3:0] MODE_DUTY_FALL  = 4'd8;
    localparam logic [3:0] MODE_TAGGED     = 4'd9;

    localparam logic [15:0] SAT16      = 16'hFFFF;
    localparam logic [14:0] TAG_SAT    = 15'h7FFF;
    localparam logic [24:0] UNIT_SCALE = 25'h10000;
    localparam logic [9:0]  MS_DIVIDEND = 10'd1000;
    localparam int          FRAC_BITS  = 16;

    typedef logic [2:0] t_op;
    localparam t_op OP_CONST  = 3'd0;
    localparam t_op OP_TIME   = 3'd1;
    localparam t_op OP_PERIOD = 3'd2;
    localparam t_op OP_FREQ   = 3'd3;
    localparam t_op OP_DUTY   = 3'd4;

    typedef struct packed {
        t_op         op;
        logic        vld;
        logic [15:0] cval;
        logic        tag_fmt;
        logic        high;
    } t_job;

    typedef struct packed {
        logic        units_ms;
        logic [3:0]  output_mode;
        logic [15:0] timeout_ticks;
        logic [23:0] us_scale;
        logic [19:0] sample_rate_hz;
    } t_cfg;

endpackage

// ===== rtl/pulse_width_period_meter.sv =====
// pulse_width_period_meter: top level with configuration registers
// plain values pass the back part's PREP and OUT states; converted times and periods also pass
// MUL and CONV; frequency and duty pass the shared divider (one quotient bit per cycle)
// one transaction per back pass: a new job is popped only in S_IDLE, after the last has left S_OUT
// reset: synchronous active-low i_rst_n clears counters, queue and output; config to defaults
module pulse_width_period_meter import pwpm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_kind,
    input  logic                   i_level,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_value_valid,
    output logic [15:0]            o_value,
    output logic [15:0]            o_hi_span,
    output logic [15:0]            o_lo_span,
    output logic [15:0]            o_fall_total,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int QW = $bits(t_job) + 3 * CW;

    t_cfg r_cfg;

    logic          push, pop, full, empty;
    t_job          f_job, b_job;
    logic [CW-1:0] f_hl, f_ll, f_ec, b_hl, b_ll, b_ec;
    logic [QW-1:0] q_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.units_ms       <= 1'b0;
            r_cfg.output_mode    <= MODE_HIGH_FALL;
            r_cfg.timeout_ticks  <= 16'd0;
            r_cfg.us_scale       <= US_SCALE_RST;
            r_cfg.sample_rate_hz <= SAMPLE_RATE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UNITS_MS:    r_cfg.units_ms       <= i_cfg_data[0];
                CFG_OUTPUT_MODE: r_cfg.output_mode    <= i_cfg_data[3:0];
                CFG_TIMEOUT:     r_cfg.timeout_ticks  <= i_cfg_data[15:0];
                CFG_US_SCALE:    r_cfg.us_scale       <= i_cfg_data[23:0];
                CFG_SAMPLE_RATE: r_cfg.sample_rate_hz <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    pwpm_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_level    (i_level),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_job      (f_job),
        .o_hl       (f_hl),
        .o_ll       (f_ll),
        .o_ec       (f_ec)
    );

    pwpm_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data ({f_job, f_hl, f_ll, f_ec}),
        .i_rd      (pop),
        .o_rd_data (q_rd_data),
        .o_full    (full),
        .o_empty   (empty)
    );

    assign {b_job, b_hl, b_ll, b_ec} = q_rd_data;

    pwpm_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_job         (b_job),
        .i_hl          (b_hl),
        .i_ll          (b_ll),
        .i_ec          (b_ec),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value_valid (o_value_valid),
        .o_value       (o_value),
        .o_hi_span     (o_hi_span),
        .o_lo_span     (o_lo_span),
        .o_fall_total  (o_fall_total)
    );

endmodule

// ===== rtl/pwpm_front.sv =====
// pwpm_front: edge detection, run length counting and job classification
// depends on pwpm_pkg; feeds jobs into pwpm_queue
module pwpm_front import pwpm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_kind,
    input  logic                   i_level,
    input  t_cfg                   i_cfg,
    input  logic                   i_full,
    output logic                   o_push,
    output t_job                   o_job,
    output logic [COUNT_WIDTH-1:0] o_hl,
    output logic [COUNT_WIDTH-1:0] o_ll,
    output logic [COUNT_WIDTH-1:0] o_ec
);

    localparam int CW = COUNT_WIDTH;

    logic          r_last, n_last;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_hl, n_hl;
    logic [CW-1:0] r_ll, n_ll;
    logic [CW-1:0] r_ec, n_ec;
    logic [15:0]   r_tc, n_tc;
    logic [CW+15:0] ec_ext;
    logic          fire;
    t_job          job;

    assign o_in_stall = i_full;
    assign fire       = i_in_valid && !i_full;
    assign ec_ext     = {16'd0, n_ec};

    always_comb begin
        n_last = r_last;
        n_run  = r_run;
        n_hl   = r_hl;
        n_ll   = r_ll;
        n_ec   = r_ec;
        n_tc   = r_tc;
        job    = '0;
        job.op = OP_CONST;
        if (i_kind) begin
            if (i_cfg.timeout_ticks != 16'd0) begin
                if (r_tc != SAT16) begin
                    n_tc = r_tc + 16'd1;
                end
                if ((i_cfg.output_mode inside {MODE_FREQ_RISE, MODE_FREQ_FALL}) &&
                    n_tc > i_cfg.timeout_ticks) begin
                    job.vld = 1'b1;
                end
            end
        end else if (i_level == r_last) begin
            n_run = r_run + CW'(1);
        end else if (i_level) begin
            // rising edge
            n_ll   = r_run;
            n_run  = CW'(1);
            n_last = 1'b1;
            case (i_cfg.output_mode)
                MODE_LOW_RISE, MODE_TAGGED: begin
                    job.op      = OP_TIME;
                    job.vld     = 1'b1;
                    job.tag_fmt = (i_cfg.output_mode == MODE_TAGGED);
                end
                MODE_PER_RISE: begin
                    job.op  = OP_PERIOD;
                    job.vld = 1'b1;
                end
                MODE_FREQ_RISE: begin
                    job.op  = OP_FREQ;
                    job.vld = 1'b1;
                end
                MODE_DUTY_RISE: begin
                    job.op  = OP_DUTY;
                    job.vld = 1'b1;
                end
                default: begin
                    job.vld = 1'b0;
                end
            endcase
        end else begin
            // falling edge
            n_hl   = r_run;
            n_run  = CW'(1);
            n_last = 1'b0;
            n_ec   = r_ec + CW'(1);
            n_tc   = 16'd0;
            case (i_cfg.output_mode)
                MODE_HIGH_FALL, MODE_TAGGED: begin
                    job.op      = OP_TIME;
                    job.vld     = 1'b1;
                    job.high    = 1'b1;
                    job.tag_fmt = (i_cfg.output_mode == MODE_TAGGED);
                end
                MODE_COUNT_FALL: begin
                    job.vld  = 1'b1;
                    job.cval = ec_ext[15:0];
                end
                MODE_PER_FALL: begin
                    job.op  = OP_PERIOD;
                    job.vld = 1'b1;
                end
                MODE_FREQ_FALL: begin
                    job.op  = OP_FREQ;
                    job.vld = 1'b1;
                end
                MODE_DUTY_FALL: begin
                    job.op  = OP_DUTY;
                    job.vld = 1'b1;
                end
                default: begin
                    job.vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
            r_run  <= '0;
            r_hl   <= '0;
            r_ll   <= '0;
            r_ec   <= '0;
            r_tc   <= '0;
        end else if (fire) begin
            r_last <= n_last;
            r_run  <= n_run;
            r_hl   <= n_hl;
            r_ll   <= n_ll;
            r_ec   <= n_ec;
            r_tc   <= n_tc;
        end
    end

    assign o_push = fire;
    assign o_job  = job;
    assign o_hl   = n_hl;
    assign o_ll   = n_ll;
    assign o_ec   = n_ec;

endmodule

// ===== rtl/pwpm_queue.sv =====
// pwpm_queue: short job queue between the front and back parts
// depends on pwpm_pkg for its default depth
module pwpm_queue import pwpm_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;

    assign o_full    = (r_count == NW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + NW'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (!o_full || i_rd))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_count == $past(r_count) + NW'(1)))
        else $error("queue count did not follow a write");
`endif

endmodule

// ===== rtl/pwpm_back.sv =====
// pwpm_back: unit conversion multiplier, iterative divider and result register
// depends on pwpm_pkg; takes jobs from pwpm_queue
module pwpm_back import pwpm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  t_job                   i_job,
    input  logic [COUNT_WIDTH-1:0] i_hl,
    input  logic [COUNT_WIDTH-1:0] i_ll,
    input  logic [COUNT_WIDTH-1:0] i_ec,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_value_valid,
    output logic [15:0]            o_value,
    output logic [15:0]            o_hi_span,
    output logic [15:0]            o_lo_span,
    output logic [15:0]            o_fall_total
);

    localparam int CW   = COUNT_WIDTH;
    localparam int DW   = CW + FRAC_BITS;
    localparam int PW   = CW + 26;
    localparam int CNTW = $clog2(DW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CONV = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_POST = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]     r_state, n_state;
    t_job           r_ctl;
    logic [CW-1:0]  r_hl, r_ll, r_ec;
    logic [CW:0]    r_mul_a, n_mul_a;
    logic [PW-1:0]  r_prod;
    logic [DW-1:0]  r_dvd, n_dvd;
    logic [CW+1:0]  r_rem, n_rem;
    logic [CW:0]    r_div, n_div;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [15:0]    r_res, n_res;

    logic           r_out_valid, r_out_vv;
    logic [15:0]    r_out_value, r_out_ht, r_out_lt, r_out_pc;

    logic [CW:0]    period;
    logic [24:0]    scale;
    logic [PW-17:0] conv;
    logic [CW+1:0]  rem_sh;
    logic           take;
    logic [DW:0]    q_round;
    logic [DW-1:0]  q_fin;
    logic [CW+15:0] hl_ext, ll_ext, ec_ext;
    logic           out_free;

    assign period   = {1'b0, r_hl} + {1'b0, r_ll};
    assign scale    = (r_ctl.op inside {OP_TIME, OP_PERIOD}) ?
                      (i_cfg.units_ms ? UNIT_SCALE : {1'b0, i_cfg.us_scale}) : UNIT_SCALE;
    assign conv     = r_prod[PW-1:FRAC_BITS];
    assign rem_sh   = {r_rem[CW:0], r_dvd[DW-1]};
    assign take     = (rem_sh >= {1'b0, r_div});
    assign q_round  = ({1'b0, r_dvd} + (DW+1)'(1)) >> 1;
    assign q_fin    = (r_ctl.op == OP_FREQ && !i_cfg.units_ms) ? q_round[DW-1:0] : r_dvd;
    assign hl_ext   = {16'd0, r_hl};
    assign ll_ext   = {16'd0, r_ll};
    assign ec_ext   = {16'd0, r_ec};
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        n_mul_a = r_mul_a;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_rem = '0;
                n_div = period;
                n_cnt = CNTW'(DW);
                case (r_ctl.op)
                    OP_TIME: begin
                        n_mul_a = r_ctl.high ? {1'b0, r_hl} : {1'b0, r_ll};
                        n_state = S_MUL;
                    end
                    OP_PERIOD: begin
                        n_mul_a = period;
                        n_state = S_MUL;
                    end
                    OP_FREQ, OP_DUTY: begin
                        if (period == '0) begin
                            n_res   = SAT16;
                            n_state = S_OUT;
                        end else begin
                            if (r_ctl.op == OP_DUTY) begin
                                n_dvd = {r_hl, 16'd0};
                            end else if (i_cfg.units_ms) begin
                                n_dvd = DW'(MS_DIVIDEND);
                            end else begin
                                n_dvd = DW'({i_cfg.sample_rate_hz, 1'b0});
                            end
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        n_res   = r_ctl.cval;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_MUL: begin
                n_state = S_CONV;
            end
            S_CONV: begin
                if (r_ctl.tag_fmt) begin
                    n_res = {r_ctl.high, (|conv[PW-17:15]) ? TAG_SAT : conv[14:0]};
                end else begin
                    n_res = (|conv[PW-17:16]) ? SAT16 : conv[15:0];
                end
                n_state = S_OUT;
            end
            S_DIV: begin
                n_rem = take ? rem_sh - {1'b0, r_div} : rem_sh;
                n_dvd = {r_dvd[DW-2:0], take};
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_res   = (|q_fin[DW-1:16]) ? SAT16 : q_fin[15:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl <= i_job;
            r_hl  <= i_hl;
            r_ll  <= i_ll;
            r_ec  <= i_ec;
        end
        r_mul_a <= n_mul_a;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_mul_a * scale);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_vv    <= r_ctl.vld;
            r_out_value <= r_ctl.vld ? r_res : 16'd0;
            r_out_ht    <= hl_ext[15:0];
            r_out_lt    <= ll_ext[15:0];
            r_out_pc    <= ec_ext[15:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_valid = r_out_vv;
    assign o_value       = r_out_value;
    assign o_hi_span     = r_out_ht;
    assign o_lo_span     = r_out_lt;
    assign o_fall_total  = r_out_pc;

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider step count ran out");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divider started with zero divisor");
`endif

endmodule
